// File: rtl/core/pce_pkg.sv
// shared types and constants for the palette colour effect core
`default_nettype none
package pce_pkg;

    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int MODE_W    = 3;
    localparam int SUM3_W    = 10;
    localparam int SEP_W     = 19;
    localparam int GAIN_W    = 9;
    localparam int PROD_W    = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTEN_PERCENT = 2'd1;

    localparam logic [MODE_W-1:0] EFFECT_MODE_RESET      = 3'd0;
    localparam logic [CHAN_W-1:0] BRIGHTEN_PERCENT_RESET = 8'd60;

    localparam logic [GAIN_W-1:0] GAIN_BASE = 9'd200;

    // sepia matrix in thousandths
    localparam logic [9:0] SEP_RR = 10'd393;
    localparam logic [9:0] SEP_RG = 10'd769;
    localparam logic [9:0] SEP_RB = 10'd189;
    localparam logic [9:0] SEP_GR = 10'd349;
    localparam logic [9:0] SEP_GG = 10'd686;
    localparam logic [9:0] SEP_GB = 10'd168;
    localparam logic [9:0] SEP_BR = 10'd272;
    localparam logic [9:0] SEP_BG = 10'd534;
    localparam logic [9:0] SEP_BB = 10'd131;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 3'd0,
        MODE_GRAY     = 3'd1,
        MODE_BLUETINT = 3'd2,
        MODE_REDTINT  = 3'd3,
        MODE_SEPIA    = 3'd4,
        MODE_BRIGHTEN = 3'd5
    } t_effect_mode;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // products and sums held between the two register stages
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_rgb              pix;
        logic [SUM3_W-1:0] sum3;
        logic [SEP_W-1:0]  sep_r;
        logic [SEP_W-1:0]  sep_g;
        logic [SEP_W-1:0]  sep_b;
        logic [PROD_W-1:0] gain_r;
        logic [PROD_W-1:0] gain_g;
        logic [PROD_W-1:0] gain_b;
    } t_mix;

endpackage
`default_nettype wire

// File: rtl/core/palette_colour_effect_core.sv
// palette colour effect core: two register stages with stall-driven flow control
// an accepted input beat goes through the product register, then the result register, before it shows on o_valid
// throughput: one beat per cycle while i_stall stays low, set by the product register and the result register
// a full pipe under i_stall holds both stages and raises o_stall
// reset (i_rst_n low, synchronous): both stages empty, effect_mode 0, brighten_percent 60
`default_nettype none
module palette_colour_effect_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [pce_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pce_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // input channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [pce_pkg::CHAN_W-1:0]       i_red_in,
    input  wire logic [pce_pkg::CHAN_W-1:0]       i_green_in,
    input  wire logic [pce_pkg::CHAN_W-1:0]       i_blue_in,
    // result channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [pce_pkg::CHAN_W-1:0]            o_red_out,
    output logic [pce_pkg::CHAN_W-1:0]            o_green_out,
    output logic [pce_pkg::CHAN_W-1:0]            o_blue_out
);
    import pce_pkg::*;

    // configuration registers
    logic [MODE_W-1:0] r_effect_mode;
    logic [CHAN_W-1:0] r_brighten_pct;

    // product stage and result stage
    logic  r_s1_valid;
    t_mix  r_s1;
    logic  r_out_valid;
    t_rgb  r_out;

    t_rgb  in_pix;
    t_mix  n_s1;
    t_rgb  n_out;
    logic  out_load;   // result register may take a new beat this cycle
    logic  s1_load;    // product register may take a new beat this cycle

    // the result register frees up when empty or when its beat is taken
    assign out_load = !r_out_valid || !i_stall;
    assign s1_load  = !r_s1_valid || out_load;
    assign o_stall  = !s1_load;

    assign in_pix.red   = i_red_in;
    assign in_pix.green = i_green_in;
    assign in_pix.blue  = i_blue_in;

    // config writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode  <= EFFECT_MODE_RESET;
            r_brighten_pct <= BRIGHTEN_PERCENT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_EFFECT_MODE) begin
                r_effect_mode <= i_cfg_data[MODE_W-1:0];
            end else if (i_cfg_idx == CFG_BRIGHTEN_PERCENT) begin
                r_brighten_pct <= i_cfg_data;
            end
        end
    end

    pce_mix u_mix (
        .i_pix  (in_pix),
        .i_mode (r_effect_mode),
        .i_pct  (r_brighten_pct),
        .o_mix  (n_s1)
    );

    pce_scale u_scale (
        .i_mix (r_s1),
        .o_pix (n_out)
    );

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1 <= n_s1;
        end
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out.red;
    assign o_green_out = r_out.green;
    assign o_blue_out  = r_out.blue;

`ifndef NO_ASSERTIONS
    // upstream only sees stall when both stages are full and downstream stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("stall raised with room in the pipe");

    // an accepted beat lands in the product stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted beat lost at product stage");

    // a product beat moving on shows up as a result
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_load) |=> o_valid)
        else $error("product beat lost at result stage");

    // grayscale gives equal channels
    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_load && (r_s1.mode == MODE_GRAY)) |=>
        ((o_red_out == o_green_out) && (o_green_out == o_blue_out)))
        else $error("grayscale channels differ");
`endif

endmodule
`default_nettype wire

// File: rtl/core/pce_mix.sv
// first stage: channel sum, sepia dot products and brighten products
`default_nettype none
module pce_mix (
    input  wire pce_pkg::t_rgb                 i_pix,
    input  wire logic [pce_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [pce_pkg::CHAN_W-1:0]    i_pct,
    output pce_pkg::t_mix                      o_mix
);
    import pce_pkg::*;

    logic [GAIN_W-1:0] gain;

    function automatic logic [SEP_W-1:0] dot3(input logic [CHAN_W-1:0] r,
                                              input logic [CHAN_W-1:0] g,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [9:0] kr,
                                              input logic [9:0] kg,
                                              input logic [9:0] kb);
        dot3 = SEP_W'(kr) * SEP_W'(r) + SEP_W'(kg) * SEP_W'(g)
             + SEP_W'(kb) * SEP_W'(b);
    endfunction

    assign gain = GAIN_BASE + GAIN_W'(i_pct);

    always_comb begin
        o_mix.mode   = i_mode;
        o_mix.pix    = i_pix;
        o_mix.sum3   = SUM3_W'(i_pix.red) + SUM3_W'(i_pix.green) + SUM3_W'(i_pix.blue);
        o_mix.sep_r  = dot3(i_pix.red, i_pix.green, i_pix.blue, SEP_RR, SEP_RG, SEP_RB);
        o_mix.sep_g  = dot3(i_pix.red, i_pix.green, i_pix.blue, SEP_GR, SEP_GG, SEP_GB);
        o_mix.sep_b  = dot3(i_pix.red, i_pix.green, i_pix.blue, SEP_BR, SEP_BG, SEP_BB);
        o_mix.gain_r = PROD_W'(i_pix.red)   * PROD_W'(gain);
        o_mix.gain_g = PROD_W'(i_pix.green) * PROD_W'(gain);
        o_mix.gain_b = PROD_W'(i_pix.blue)  * PROD_W'(gain);
    end

endmodule
`default_nettype wire

// File: rtl/core/pce_scale.sv
// second stage: constant divides, saturation and effect select
`default_nettype none
module pce_scale (
    input  wire pce_pkg::t_mix i_mix,
    output pce_pkg::t_rgb      o_pix
);
    import pce_pkg::*;

    logic [CHAN_W-1:0] avg;
    logic [CHAN_W-1:0] sep_r, sep_g, sep_b;
    logic [CHAN_W-1:0] bri_r, bri_g, bri_b;
    logic [20:0]       avg_prod;

    // floor(s/1000) by reciprocal 268436 / 2^28, exact for s up to 493998
    function automatic logic [CHAN_W-1:0] div1000_sat(input logic [SEP_W-1:0] s);
        logic [37:0] p;
        logic [8:0]  q;
        p = 38'(s) * 38'(268436);
        q = p[36:28];
        div1000_sat = (q > 9'd255) ? 8'hFF : q[7:0];
    endfunction

    // floor(s/100) by reciprocal 167773 / 2^24, exact for s below 2^17
    function automatic logic [CHAN_W-1:0] div100_sat(input logic [PROD_W-1:0] s);
        logic [34:0] p;
        logic [10:0] q;
        p = 35'(s) * 35'(167773);
        q = p[34:24];
        div100_sat = (q > 11'd255) ? 8'hFF : q[7:0];
    endfunction

    // floor(x/3) as x*683 >> 11, exact for x up to 765
    assign avg_prod = 21'(i_mix.sum3) * 21'(683);
    assign avg      = avg_prod[18:11];

    assign sep_r = div1000_sat(i_mix.sep_r);
    assign sep_g = div1000_sat(i_mix.sep_g);
    assign sep_b = div1000_sat(i_mix.sep_b);
    assign bri_r = div100_sat(i_mix.gain_r);
    assign bri_g = div100_sat(i_mix.gain_g);
    assign bri_b = div100_sat(i_mix.gain_b);

    always_comb begin
        o_pix = i_mix.pix;
        unique case (t_effect_mode'(i_mix.mode))
            MODE_GRAY: begin
                o_pix.red   = avg;
                o_pix.green = avg;
                o_pix.blue  = avg;
            end
            MODE_BLUETINT: begin
                o_pix.red   = avg;
                o_pix.green = avg;
            end
            MODE_REDTINT: begin
                o_pix.green = avg;
                o_pix.blue  = avg;
            end
            MODE_SEPIA: begin
                o_pix.red   = sep_r;
                o_pix.green = sep_g;
                o_pix.blue  = sep_b;
            end
            MODE_BRIGHTEN: begin
                o_pix.red   = bri_r;
                o_pix.green = bri_g;
                o_pix.blue  = bri_b;
            end
            default: begin
                o_pix = i_mix.pix;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: bench/tb_palette_colour_effect_core.sv
// self-checking testbench for the palette colour effect core
module tb_palette_colour_effect_core;
    import pce_pkg::*;

    // register indexes the core decodes as no register at all
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
    // effect codes past brighten, expected to behave as pass-through
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int unsigned CHAN_MAX       = 255;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          HOLD_CYCLES    = 60;
    localparam int          PHASES         = 24;
    localparam int          PHASE_BEATS    = 60;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          TAIL_CYCLES    = 8;

    // expected colours in acceptance order, with a private copy of the registers
    class effect_tracker;
        logic [MODE_W-1:0] mode_reg;
        logic [CHAN_W-1:0] percent_reg;
        t_rgb              expected_q[$];
        int                mismatches;

        function new();
            mode_reg    = EFFECT_MODE_RESET;
            percent_reg = BRIGHTEN_PERCENT_RESET;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_EFFECT_MODE:      mode_reg    = data[MODE_W-1:0];
                CFG_BRIGHTEN_PERCENT: percent_reg = data;
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] clip(int unsigned v);
            return (v > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : v[CHAN_W-1:0];
        endfunction

        function t_rgb apply_effect(t_rgb px);
            int unsigned r, g, b, avg, gain;
            t_rgb        res;
            r    = px.red;
            g    = px.green;
            b    = px.blue;
            avg  = (r + g + b) / 3;
            gain = GAIN_BASE + percent_reg;
            res  = px;
            case (mode_reg)
                MODE_GRAY: begin
                    res = '{avg[CHAN_W-1:0], avg[CHAN_W-1:0], avg[CHAN_W-1:0]};
                end
                MODE_BLUETINT: begin
                    res.red   = avg[CHAN_W-1:0];
                    res.green = avg[CHAN_W-1:0];
                end
                MODE_REDTINT: begin
                    res.green = avg[CHAN_W-1:0];
                    res.blue  = avg[CHAN_W-1:0];
                end
                MODE_SEPIA: begin
                    res.red   = clip((SEP_RR * r + SEP_RG * g + SEP_RB * b) / 1000);
                    res.green = clip((SEP_GR * r + SEP_GG * g + SEP_GB * b) / 1000);
                    res.blue  = clip((SEP_BR * r + SEP_BG * g + SEP_BB * b) / 1000);
                end
                MODE_BRIGHTEN: begin
                    res.red   = clip((r * gain) / 100);
                    res.green = clip((g * gain) / 100);
                    res.blue  = clip((b * gain) / 100);
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_entry(t_rgb px);
            expected_q.push_back(apply_effect(px));
        endfunction

        function void report(string what, t_rgb want, t_rgb got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%s: expected %0d/%0d/%0d got %0d/%0d/%0d", what,
                         want.red, want.green, want.blue, got.red, got.green, got.blue);
        endfunction

        function void check_entry(t_rgb got);
            t_rgb want;
            if (expected_q.size() == 0) begin
                report("unexpected result beat", got, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
                report("colour mismatch", want, got);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_EFFECT_MODE;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [CHAN_W-1:0]    i_red_in    = '0;
    logic [CHAN_W-1:0]    i_green_in  = '0;
    logic [CHAN_W-1:0]    i_blue_in   = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b1;
    logic [CHAN_W-1:0]    o_red_out;
    logic [CHAN_W-1:0]    o_green_out;
    logic [CHAN_W-1:0]    o_blue_out;

    effect_tracker tracker = new();

    // idle rates in percent, changed between phases
    int   send_idle_pct  = 18;
    int   recv_stall_pct = 75;
    // a flip of hold_toggle asks the receiver for one long hold-off
    logic hold_toggle    = 1'b0;
    logic hold_seen      = 1'b0;
    int   hold_left      = 0;

    palette_colour_effect_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stall, or a long hold-off when asked so the pipe backs up
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall   <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // both handshakes sampled at the edge, before any of this step's drives land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                tracker.note_entry('{i_red_in, i_green_in, i_blue_in});
            if (o_valid && !i_stall)
                tracker.check_entry('{o_red_out, o_green_out, o_blue_out});
        end
    end

    // offer one beat, idling first at the current rate, and hold it until taken
    task automatic send_rgb(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // stop offering, wait for every expected colour, then let the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        // wait so the monitor has logged the last accepted beat
        @(posedge i_clk);
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_effect(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] pct);
        settle();
        cfg_write(CFG_EFFECT_MODE, CFG_DAT_W'(mode));
        cfg_write(CFG_BRIGHTEN_PERCENT, pct);
    endtask

    // channel value biased towards the extremes
    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic run_random_phase(input int phase_no);
        logic [MODE_W-1:0]    mode;
        logic [CFG_DAT_W-1:0] mode_word;
        logic [CHAN_W-1:0]    pct;
        settle();
        // every code once per idling profile, upper data bits random
        mode                   = MODE_W'(phase_no % 8);
        mode_word              = CFG_DAT_W'($urandom);
        mode_word[MODE_W-1:0]  = mode;
        case (phase_no % 5)
            0:       pct = '0;
            1:       pct = '1;
            default: pct = CHAN_W'($urandom_range(255));
        endcase
        cfg_write(CFG_EFFECT_MODE, mode_word);
        cfg_write(CFG_BRIGHTEN_PERCENT, pct);
        if ($urandom_range(3) == 0)
            cfg_write($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                      CFG_DAT_W'($urandom));
        // long receiver hold-off while the sender keeps pushing
        if (phase_no % 8 == 3)
            hold_toggle <= ~hold_toggle;
        repeat (PHASE_BEATS)
            send_rgb(pick_chan(), pick_chan(), pick_chan());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: pass-through first
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'hA5, 8'h5A, 8'h0F);
        // brighten with the reset percent still in place
        settle();
        cfg_write(CFG_EFFECT_MODE, CFG_DAT_W'(MODE_BRIGHTEN));
        send_rgb(8'd100, 8'd159, 8'd160);

        set_effect(MODE_GRAY, 8'd60);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd1, 8'd1, 8'd0);
        send_rgb(8'd255, 8'd254, 8'd0);
        set_effect(MODE_BLUETINT, 8'd60);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        set_effect(MODE_REDTINT, 8'd60);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd255);
        // sepia saturates red and green on white, stays exact on small values
        set_effect(MODE_SEPIA, 8'd60);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd100, 8'd50, 8'd20);
        // largest and smallest brighten gain
        set_effect(MODE_BRIGHTEN, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd56);
        send_rgb(8'd1, 8'd43, 8'd128);
        set_effect(MODE_BRIGHTEN, 8'd0);
        send_rgb(8'd127, 8'd128, 8'd99);
        // spare effect codes pass the colour through
        set_effect(MODE_SPARE_6, 8'd60);
        send_rgb(8'd12, 8'd34, 8'd56);
        set_effect(MODE_SPARE_7, 8'd60);
        send_rgb(8'd200, 8'd100, 8'd50);
        // writes to unknown indexes must leave both registers alone
        settle();
        cfg_write(CFG_UNUSED_A, 8'hFF);
        cfg_write(CFG_UNUSED_B, 8'h04);
        send_rgb(8'd250, 8'd5, 8'd77);

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES / 3) begin
                send_idle_pct  = 75;
                recv_stall_pct = 18;
            end else if (p == 2 * PHASES / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            run_random_phase(p);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/pce_pkg.sv
rtl/core/pce_mix.sv
rtl/core/pce_scale.sv
rtl/core/palette_colour_effect_core.sv
bench/tb_palette_colour_effect_core.sv
